// File: rtl/bxavg_pkg.sv
// shared constants, types and the reciprocal table of the box-average downscaler
package bxavg_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 4096;
    localparam int MAX_FACTOR_DEFAULT = 16;
    localparam int MAX_HEIGHT         = 4096;

    localparam int PIXEL_W     = 8;
    localparam int FACTOR_W    = 5;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int HEIGHT_W    = 13;
    localparam int ROW_W       = 12;

    localparam int FACTOR_RESET = 16;
    localparam int WIDTH_RESET  = 4096;
    localparam int HEIGHT_RESET = 4096;

    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic               frame_last;
        logic [PIXEL_W-1:0] average;
    } result_t;

    // ceil(2^24 / (f*f)), exact floor division for any 16-bit block sum
    function automatic logic [RECIP_W-1:0] recip(input logic [FACTOR_W-1:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            5'd2:    r = 25'd4194304;
            5'd3:    r = 25'd1864136;
            5'd4:    r = 25'd1048576;
            5'd5:    r = 25'd671089;
            5'd6:    r = 25'd466034;
            5'd7:    r = 25'd342393;
            5'd8:    r = 25'd262144;
            5'd9:    r = 25'd207127;
            5'd10:   r = 25'd167773;
            5'd11:   r = 25'd138655;
            5'd12:   r = 25'd116509;
            5'd13:   r = 25'd99274;
            5'd14:   r = 25'd85599;
            5'd15:   r = 25'd74566;
            5'd16:   r = 25'd65536;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bxavg_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module bxavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bxavg_queue.sv
// small result queue between the averaging pipeline and the output channel
module bxavg_queue (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         push,
    input  bxavg_pkg::result_t                           push_data,
    input  logic                                         pop,
    output bxavg_pkg::result_t                           head,
    output logic [$clog2(bxavg_pkg::QUEUE_DEPTH+1)-1:0] count
);
    import bxavg_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t          entry_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: rtl/box_average_image_downscaler.sv
// top level of the box-average image downscaler
//
// Gray source pixels enter in raster order on the in_valid/in_ready channel,
// one transaction per pixel; frame_start marks position (0,0) of a frame.
// Each factor-by-factor block gives one average on the out_valid/out_ready
// channel, with frame_last set on the final block of the frame.
// Configuration is written through cfg_write/cfg_index/cfg_data while the
// block is idle; every write to one of the three registers restarts the raster position.
// Throughput: one pixel per clock cycle while in_ready is high. A pixel is taken while
// up to three results are in flight or queued; per-column block sums live in one ram
// that is read at accept and written back in the following cycle, with forwarding.
// The sum of a block whose closing pixel is accepted passes the write-back and scaling
// stages into the output queue, which raises out_valid. When the receiver stalls, up
// to four results are held in the queue, then in_ready drops until a result is taken.
// Reset: factor 16, width 4096, height 4096, position (0,0), queue empty;
// the column-sum ram needs no clearing since each entry is written on the
// first row of a block row before it is read.
module box_average_image_downscaler #(
    parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [bxavg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bxavg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bxavg_pkg::PIXEL_W-1:0]     pixel,
    input  logic                               frame_start,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bxavg_pkg::PIXEL_W-1:0]     average,
    output logic                               frame_last
);
    import bxavg_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int FBW   = $clog2(MAX_FACTOR);
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int RW    = PIXEL_W + FBW;
    localparam int SW    = PIXEL_W + 2 * FBW;
    localparam int PW    = SW + RECIP_W;
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int F_RST = (FACTOR_RESET > MAX_FACTOR) ? MAX_FACTOR : FACTOR_RESET;
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    // configuration, stored already clamped
    logic [FW-1:0]        f_reg, f_next;
    logic [CW:0]          w_reg, w_next;
    logic [HEIGHT_W-1:0]  h_reg, h_next;

    // raster position
    logic [CW-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [FBW-1:0]       cib_reg, cib_next;
    logic [FBW-1:0]       rib_reg, rib_next;
    logic [CW-1:0]        bc_reg, bc_next;
    logic [CW-1:0]        cbs_reg, cbs_next;
    logic [ROW_W-1:0]     rbs_reg, rbs_next;
    logic [RW-1:0]        run_reg, run_next;

    // write-back stage
    logic                 b_valid_reg;
    logic [CW-1:0]        b_addr_reg;
    logic [RW-1:0]        b_part_reg;
    logic                 b_first_reg;
    logic                 b_emit_reg;
    logic                 b_last_reg;
    logic                 b_fwd_reg;
    logic [SW-1:0]        b_fwd_data_reg;

    // scaling stage
    logic                 c_valid_reg;
    logic [SW-1:0]        c_sum_reg;
    logic                 c_last_reg;

    logic                 accept;
    logic                 cfg_hit;
    logic [FACTOR_W-1:0]  f_raw, f_clamp;
    logic [CFG_DATA_W:0]  w_raw, w_clamp;
    logic [HEIGHT_W-1:0]  h_raw, h_clamp;

    logic [CW-1:0]        col_e, bc_e, cbs_e;
    logic [ROW_W-1:0]     row_e, rbs_e;
    logic [FBW-1:0]       cib_e, rib_e;
    logic [RW-1:0]        run_e, row_sum;
    logic                 in_area, cib_last, complete;
    logic                 rib_first, rib_last, last_cblk, last_rblk;
    logic                 col_wrap, row_wrap, cib_wrap, rib_wrap;
    logic                 fwd_hit;

    logic [SW-1:0]        ram_rdata, prev_sum, b_sum;
    logic [PW-1:0]        product;
    result_t              push_data, head;
    logic [QCW-1:0]       q_count;
    logic [QCW:0]         in_flight;

    assign accept  = in_valid && in_ready;
    assign cfg_hit = cfg_write && (cfg_index == REG_FACTOR || cfg_index == REG_WIDTH
                                   || cfg_index == REG_HEIGHT);

    // clamp of the written values
    always_comb
    begin
        f_raw = cfg_data[FACTOR_W-1:0];
        w_raw = {1'b0, cfg_data};
        h_raw = cfg_data[HEIGHT_W-1:0];
        if (f_raw == '0)
            f_clamp = FACTOR_W'(1);
        else if (f_raw > FACTOR_W'(MAX_FACTOR))
            f_clamp = FACTOR_W'(MAX_FACTOR);
        else
            f_clamp = f_raw;
        if (w_raw == '0)
            w_clamp = (CFG_DATA_W + 1)'(1);
        else if (w_raw > (CFG_DATA_W + 1)'(MAX_WIDTH))
            w_clamp = (CFG_DATA_W + 1)'(MAX_WIDTH);
        else
            w_clamp = w_raw;
        if (h_raw == '0)
            h_clamp = HEIGHT_W'(1);
        else if (h_raw > HEIGHT_W'(MAX_HEIGHT))
            h_clamp = HEIGHT_W'(MAX_HEIGHT);
        else
            h_clamp = h_raw;

        f_next = f_reg;
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FACTOR: f_next = FW'(f_clamp);
                REG_WIDTH:  w_next = (CW + 1)'(w_clamp);
                REG_HEIGHT: h_next = h_clamp;
                default:    ;
            endcase
        end
    end

    // position of the incoming pixel and block bookkeeping
    always_comb
    begin
        col_e = frame_start ? '0 : col_reg;
        row_e = frame_start ? '0 : row_reg;
        cib_e = frame_start ? '0 : cib_reg;
        rib_e = frame_start ? '0 : rib_reg;
        bc_e  = frame_start ? '0 : bc_reg;
        cbs_e = frame_start ? '0 : cbs_reg;
        rbs_e = frame_start ? '0 : rbs_reg;
        run_e = frame_start ? '0 : run_reg;

        in_area = (({2'b00, cbs_e} + (CW + 2)'(f_reg)) <= (CW + 2)'(w_reg))
               && (({2'b00, rbs_e} + (ROW_W + 2)'(f_reg)) <= (ROW_W + 2)'(h_reg));
        last_cblk = ({2'b00, cbs_e} + (CW + 2)'({f_reg, 1'b0})) > (CW + 2)'(w_reg);
        last_rblk = ({2'b00, rbs_e} + (ROW_W + 2)'({f_reg, 1'b0})) > (ROW_W + 2)'(h_reg);
        cib_last  = FW'(cib_e) == (f_reg - FW'(1));
        rib_last  = FW'(rib_e) == (f_reg - FW'(1));
        rib_first = rib_e == '0;
        row_sum   = run_e + RW'(pixel);
        complete  = in_area && cib_last;

        col_wrap = ((CW + 1)'(col_e) + (CW + 1)'(1)) >= w_reg;
        row_wrap = (HEIGHT_W'(row_e) + HEIGHT_W'(1)) >= h_reg;
        cib_wrap = (FW'(cib_e) + FW'(1)) >= f_reg;
        rib_wrap = (FW'(rib_e) + FW'(1)) >= f_reg;

        fwd_hit = b_valid_reg && (b_addr_reg == bc_e);

        run_next = run_e;
        if (in_area)
        begin
            run_next = cib_last ? '0 : row_sum;
        end

        col_next = col_e;
        row_next = row_e;
        cib_next = cib_e;
        rib_next = rib_e;
        bc_next  = bc_e;
        cbs_next = cbs_e;
        rbs_next = rbs_e;
        if (col_wrap)
        begin
            col_next = '0;
            cib_next = '0;
            bc_next  = '0;
            cbs_next = '0;
            run_next = '0;
            if (row_wrap)
            begin
                row_next = '0;
                rib_next = '0;
                rbs_next = '0;
            end
            else
            begin
                row_next = row_e + ROW_W'(1);
                if (rib_wrap)
                begin
                    rib_next = '0;
                    rbs_next = ROW_W'(row_e + ROW_W'(1));
                end
                else
                begin
                    rib_next = rib_e + FBW'(1);
                end
            end
        end
        else
        begin
            col_next = col_e + CW'(1);
            if (cib_wrap)
            begin
                cib_next = '0;
                bc_next  = bc_e + CW'(1);
                cbs_next = col_e + CW'(1);
            end
            else
            begin
                cib_next = cib_e + FBW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg   <= FW'(F_RST);
            w_reg   <= (CW + 1)'(W_RST);
            h_reg   <= HEIGHT_W'(HEIGHT_RESET);
            col_reg <= '0;
            row_reg <= '0;
            cib_reg <= '0;
            rib_reg <= '0;
            bc_reg  <= '0;
            cbs_reg <= '0;
            rbs_reg <= '0;
            run_reg <= '0;
        end
        else
        begin
            f_reg <= f_next;
            w_reg <= w_next;
            h_reg <= h_next;
            if (cfg_hit)
            begin
                col_reg <= '0;
                row_reg <= '0;
                cib_reg <= '0;
                rib_reg <= '0;
                bc_reg  <= '0;
                cbs_reg <= '0;
                rbs_reg <= '0;
                run_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                cib_reg <= cib_next;
                rib_reg <= rib_next;
                bc_reg  <= bc_next;
                cbs_reg <= cbs_next;
                rbs_reg <= rbs_next;
                run_reg <= run_next;
            end
        end
    end

    // column-sum read-modify-write
    bxavg_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .clk     (clk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_addr_reg),
        .wr_data (b_sum),
        .rd_en   (accept && complete && !rib_first),
        .rd_addr (bc_e),
        .rd_data (ram_rdata)
    );

    assign prev_sum = b_fwd_reg ? b_fwd_data_reg : ram_rdata;
    assign b_sum    = b_first_reg ? SW'(b_part_reg) : prev_sum + SW'(b_part_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept && complete;
            c_valid_reg <= b_valid_reg && b_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_addr_reg     <= bc_e;
        b_part_reg     <= row_sum;
        b_first_reg    <= rib_first;
        b_emit_reg     <= rib_last;
        b_last_reg     <= last_cblk && last_rblk;
        b_fwd_reg      <= fwd_hit;
        b_fwd_data_reg <= b_sum;
        c_sum_reg      <= b_sum;
        c_last_reg     <= b_last_reg;
    end

    // mean by reciprocal multiply, registered in the queue
    assign product              = PW'(c_sum_reg) * PW'(recip(FACTOR_W'(f_reg)));
    assign push_data.average    = product[RECIP_SHIFT +: PIXEL_W];
    assign push_data.frame_last = c_last_reg;

    bxavg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (c_valid_reg),
        .push_data (push_data),
        .pop       (out_valid && out_ready),
        .head      (head),
        .count     (q_count)
    );

    assign in_flight = (QCW + 1)'(q_count) + (QCW + 1)'(b_valid_reg && b_emit_reg)
                     + (QCW + 1)'(c_valid_reg);
    assign in_ready   = in_flight < (QCW + 1)'(QUEUE_DEPTH);
    assign out_valid  = q_count != '0;
    assign average    = head.average;
    assign frame_last = head.frame_last;

endmodule
